[rtl/gdbd_pkg.sv]
// gdbd_pkg: constants, widths and month tables for the gregorian day count unit
// used by gregorian_days_between_dates_unit and gdbd_checker; no dependencies
package gdbd_pkg;

  localparam int unsigned DAY_W       = 5;
  localparam int unsigned MONTH_W     = 4;
  localparam int unsigned YEAR_W      = 14;
  localparam int unsigned COUNT_W     = 22;
  localparam int unsigned IN_DATA_W   = 48;
  localparam int unsigned OUT_DATA_W  = 24;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned APB_DATA_W  = 32;

  localparam int unsigned MAX_YEAR      = 9999;
  localparam int unsigned YEAR_OFFSET   = 399;
  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned MONTHS        = 12;
  localparam int unsigned MONTH_FEB     = 2;
  localparam int unsigned LEAP_DAY      = 29;
  localparam int unsigned CENTURY_DIV   = 25;

  // floor(x / 25) = (x * RECIP_25) >> RECIP_SHIFT for x below 4700
  localparam int unsigned RECIP_25    = 5243;
  localparam int unsigned RECIP_SHIFT = 17;

  localparam int unsigned SHIFTED_W = YEAR_W + 1;
  localparam int unsigned PROD_W    = 26;
  localparam int unsigned QUO_W     = PROD_W - RECIP_SHIFT;
  localparam int unsigned NUM_W     = 24;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // register index of count_end_day
  localparam logic [0:0] REG_COUNT_END_DAY = 1'b0;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] db;
    case (m)
      4'd1:    db = 9'd0;
      4'd2:    db = 9'd31;
      4'd3:    db = 9'd59;
      4'd4:    db = 9'd90;
      4'd5:    db = 9'd120;
      4'd6:    db = 9'd151;
      4'd7:    db = 9'd181;
      4'd8:    db = 9'd212;
      4'd9:    db = 9'd243;
      4'd10:   db = 9'd273;
      4'd11:   db = 9'd304;
      4'd12:   db = 9'd334;
      default: db = 9'd0;
    endcase
    return db;
  endfunction

endpackage

[rtl/gregorian_days_between_dates_unit.sv]
// gregorian_days_between_dates_unit: five-stage pipeline for the day count between two dates
// depends on gdbd_pkg
//
// One date pair enters per clock while s_axis_tready is high, and its result leaves from
// stage five; the pipeline holds up to five pairs, and m_axis_tready low while a result
// waits freezes every stage at once. Each date becomes a serial day number in closed form:
// the divisions by 100 and 400 are 13-bit reciprocal multiplies in stage two, leap and
// validity come out in stage three, the day number is summed in stage four, and the
// difference plus count_end_day is registered in stage five. A date with a zero day or
// month, a month above 12, a year above 9999 or a day past its month's end gives
// date_invalid with a count of 0.
module gregorian_days_between_dates_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // start_day, start_month, start_year, end_day, end_month, end_year, 2 zero bits
  input  logic [gdbd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // day_count, 2 zero bits
  output logic [gdbd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // date_invalid
  output logic                                m_axis_tuser,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gdbd_pkg::ADDR_W-1:0]         paddr,
  input  logic [gdbd_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [gdbd_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int unsigned DW = gdbd_pkg::DAY_W;
  localparam int unsigned MW = gdbd_pkg::MONTH_W;
  localparam int unsigned YW = gdbd_pkg::YEAR_W;
  localparam int unsigned PW = gdbd_pkg::SHIFTED_W;
  localparam int unsigned XW = gdbd_pkg::PROD_W;
  localparam int unsigned QW = gdbd_pkg::QUO_W;
  localparam int unsigned NW = gdbd_pkg::NUM_W;
  localparam int unsigned CW = gdbd_pkg::COUNT_W;

  logic count_end_day;
  logic adv;
  logic v1, v2, v3, v4, v5;

  logic [DW-1:0] din_d [2];
  logic [MW-1:0] din_m [2];
  logic [YW-1:0] din_y [2];

  // stage 1
  logic [PW-1:0] p1 [2];
  logic [YW-1:0] y1 [2];
  logic [MW-1:0] m1 [2];
  logic [DW-1:0] d1 [2];
  logic          rng_ok1 [2];
  logic          len_ok1 [2];
  logic          feb29_1 [2];

  // stage 2
  logic [XW-1:0] prod_p100 [2];
  logic [XW-1:0] prod_p400 [2];
  logic [XW-1:0] prod_y100 [2];
  logic [XW-1:0] prod_y400 [2];
  logic [NW-1:0] p365_2 [2];
  logic [PW-1:0] p2 [2];
  logic [YW-1:0] y2 [2];
  logic [MW-1:0] m2 [2];
  logic [DW-1:0] d2 [2];
  logic          rng_ok2 [2];
  logic          len_ok2 [2];
  logic          feb29_2 [2];

  // stage 3
  logic [NW-1:0] na3 [2];
  logic [MW-1:0] m3 [2];
  logic [DW-1:0] d3 [2];
  logic          leap3 [2];
  logic          ok3 [2];
  logic [NW-1:0] na3_next [2];
  logic          leap3_next [2];
  logic          ok3_next [2];

  // stage 4
  logic [NW-1:0] n4 [2];
  logic [NW-1:0] n4_next [2];
  logic          ok4;

  // stage 5
  logic [CW-1:0] count5;
  logic          invalid5;
  logic [NW-1:0] diff;
  logic [NW-1:0] total;
  logic [CW-1:0] count5_next;

  assign adv           = !v5 || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = v5;
  assign m_axis_tdata  = {{(gdbd_pkg::OUT_DATA_W - CW){1'b0}}, count5};
  assign m_axis_tuser  = invalid5;
  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == gdbd_pkg::REG_COUNT_END_DAY) ?
                         {{(gdbd_pkg::APB_DATA_W - 1){1'b0}}, count_end_day} : '0;

  assign din_d[0] = s_axis_tdata[4:0];
  assign din_m[0] = s_axis_tdata[8:5];
  assign din_y[0] = s_axis_tdata[22:9];
  assign din_d[1] = s_axis_tdata[27:23];
  assign din_m[1] = s_axis_tdata[31:28];
  assign din_y[1] = s_axis_tdata[45:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      count_end_day <= 1'b1;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == gdbd_pkg::REG_COUNT_END_DAY) begin
      count_end_day <= pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // stage 3 combinational: quotients, leap year, validity, partial day number
  always_comb begin
    logic [QW-1:0] q_p100;
    logic [QW-1:0] q_p400;
    logic [QW-1:0] q_y100;
    logic [QW-1:0] q_y400;
    logic [YW-3:0] y_div4;
    logic [YW-3:0] y_div16;
    for (int i = 0; i < 2; i++) begin
      q_p100  = prod_p100[i][XW-1:gdbd_pkg::RECIP_SHIFT];
      q_p400  = prod_p400[i][XW-1:gdbd_pkg::RECIP_SHIFT];
      q_y100  = prod_y100[i][XW-1:gdbd_pkg::RECIP_SHIFT];
      q_y400  = prod_y400[i][XW-1:gdbd_pkg::RECIP_SHIFT];
      y_div4  = y2[i][YW-1:2];
      y_div16 = (YW-2)'(y2[i][YW-1:4]);
      leap3_next[i] =
        (y2[i][1:0] == 2'b00 &&
         y_div4 != (YW-2)'(q_y100) * (YW-2)'(gdbd_pkg::CENTURY_DIV)) ||
        (y2[i][3:0] == 4'b0000 &&
         y_div16 == (YW-2)'(q_y400) * (YW-2)'(gdbd_pkg::CENTURY_DIV));
      ok3_next[i] = rng_ok2[i] && (len_ok2[i] || (feb29_2[i] && leap3_next[i]));
      na3_next[i] = p365_2[i] + NW'(p2[i][PW-1:2]) - NW'(q_p100) + NW'(q_p400);
    end
  end

  // stage 4 combinational: month offset, leap day, day of month
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      n4_next[i] = na3[i] + NW'(gdbd_pkg::days_before(m3[i])) +
                   NW'(m3[i] > MW'(gdbd_pkg::MONTH_FEB) && leap3[i]) + NW'(d3[i]);
    end
  end

  // stage 5 combinational: difference (zero if the end date precedes the start), end day, saturation, zero if invalid
  always_comb begin
    diff  = (n4[1] > n4[0]) ? (n4[1] - n4[0]) : '0;
    total = diff + NW'(count_end_day);
    if (!ok4) begin
      count5_next = '0;
    end else if (total > NW'(gdbd_pkg::COUNT_MAX)) begin
      count5_next = gdbd_pkg::COUNT_MAX;
    end else begin
      count5_next = total[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 2; i++) begin
        // stage 1
        p1[i]      <= PW'(din_y[i]) + PW'(gdbd_pkg::YEAR_OFFSET);
        y1[i]      <= din_y[i];
        m1[i]      <= din_m[i];
        d1[i]      <= din_d[i];
        rng_ok1[i] <= din_m[i] != '0 && din_m[i] <= MW'(gdbd_pkg::MONTHS) &&
                      din_d[i] != '0 && din_y[i] <= YW'(gdbd_pkg::MAX_YEAR);
        len_ok1[i] <= din_d[i] <= gdbd_pkg::month_len(din_m[i]);
        feb29_1[i] <= din_m[i] == MW'(gdbd_pkg::MONTH_FEB) &&
                      din_d[i] == DW'(gdbd_pkg::LEAP_DAY);
        // stage 2
        prod_p100[i] <= XW'(p1[i][PW-1:2]) * XW'(gdbd_pkg::RECIP_25);
        prod_p400[i] <= XW'(p1[i][PW-1:4]) * XW'(gdbd_pkg::RECIP_25);
        prod_y100[i] <= XW'(y1[i][YW-1:2]) * XW'(gdbd_pkg::RECIP_25);
        prod_y400[i] <= XW'(y1[i][YW-1:4]) * XW'(gdbd_pkg::RECIP_25);
        p365_2[i]    <= NW'(p1[i]) * NW'(gdbd_pkg::DAYS_PER_YEAR);
        p2[i]        <= p1[i];
        y2[i]        <= y1[i];
        m2[i]        <= m1[i];
        d2[i]        <= d1[i];
        rng_ok2[i]   <= rng_ok1[i];
        len_ok2[i]   <= len_ok1[i];
        feb29_2[i]   <= feb29_1[i];
        // stage 3
        na3[i]   <= na3_next[i];
        m3[i]    <= m2[i];
        d3[i]    <= d2[i];
        leap3[i] <= leap3_next[i];
        ok3[i]   <= ok3_next[i];
        // stage 4
        n4[i] <= n4_next[i];
      end
      ok4      <= ok3[0] && ok3[1];
      // stage 5
      count5   <= count5_next;
      invalid5 <= !ok4;
    end
  end

endmodule

[rtl/gdbd_checker.sv]
// gdbd_checker: port-level assertions for gregorian_days_between_dates_unit, with its bind
// depends on gdbd_pkg
module gdbd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [gdbd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input logic                                m_axis_tuser
);

  // a stalled output transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output transaction changed while stalled");

  // an invalid date pair always reports a zero count
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("invalid date pair with nonzero count");

  // input is taken exactly when the output side is free or draining
  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output state");

  // nothing leaves the pipeline right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind gregorian_days_between_dates_unit gdbd_checker u_gdbd_checker (.*);
